FILE: rtl/core/mexm_pkg.sv
`default_nettype none
package mexm_pkg;

  localparam int MAX_PATTERN_LEN = 16;
  localparam int NUM_PATTERNS    = 8;

  // Field widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 3;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 3;
  localparam int TICK_W   = 16;

  localparam int WIN_W   = MAX_PATTERN_LEN * BYTE_W;
  localparam int SHIFT_W = $clog2(MAX_PATTERN_LEN);

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(60);

  typedef enum logic [OP_W-1:0] {
    OP_BYTE   = 3'd0,
    OP_TICK   = 3'd1,
    OP_FAULT  = 3'd2,
    OP_START  = 3'd3,
    OP_WRBYTE = 3'd4,
    OP_WRHEAD = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 3'd0,
    ST_SUCCESS = 3'd1,
    ST_ERROR   = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_FAULT   = 3'd4
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/modem_expect_matcher.sv
`default_nettype none
// Channel   Ports                                   Direction  Transfer when
// --------  --------------------------------------  ---------  ------------------------
// input     in_valid/in_ready, in_operation ...     in         in_valid & in_ready
// result    out_valid/out_ready, out_status, ...    out        out_valid & out_ready
// config    cfg_we, cfg_wdata (timeout_ticks)       in         cfg_we (no wait)
//
// Every input transfer yields exactly one result transfer. A received byte while
// waiting is scanned over the 8 slots in turn, each a pattern row read (S_FETCH)
// then the shared row compare (S_CMP), and S_DONE loads the output register when free.
// All other operations finish in the transfer cycle; the result shows next cycle.
// in_ready is low during a slot scan and while the output register is full and not
// being drained. Reset is synchronous, active low; the pattern store needs no clearing.
module modem_expect_matcher (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mexm_pkg::OP_W-1:0]        in_operation,
  input  wire logic [mexm_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic [mexm_pkg::SLOT_W-1:0]      in_slot,
  input  wire logic [mexm_pkg::POS_W-1:0]       in_position,
  input  wire logic [mexm_pkg::LEN_W-1:0]       in_pattern_length,
  input  wire logic                             in_is_error,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mexm_pkg::STATUS_W-1:0]         out_status,
  output logic [mexm_pkg::SLOT_W-1:0]           out_matched_slot,
  input  wire logic                             cfg_we,
  input  wire logic [mexm_pkg::TICK_W-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r;

  // Window: byte k at bits [8k +: 8], newest byte in the top lane
  logic [mexm_pkg::WIN_W-1:0]    win_r;
  logic [mexm_pkg::TICK_W-1:0]   timeout_r;
  logic [mexm_pkg::TICK_W-1:0]   elapsed_r;
  logic [mexm_pkg::TICK_W-1:0]   elapsed_inc;
  logic                          waiting_r;

  logic [mexm_pkg::LEN_W-1:0]    slot_len_r [mexm_pkg::NUM_PATTERNS];
  logic                          slot_err_r [mexm_pkg::NUM_PATTERNS];

  // Pattern store: one row per slot, byte-lane writes
  logic [mexm_pkg::WIN_W-1:0]    pat_mem [mexm_pkg::NUM_PATTERNS];
  logic [mexm_pkg::WIN_W-1:0]    pat_rd_r;
  logic [mexm_pkg::LEN_W-1:0]    len_rd_r;
  logic                          err_rd_r;

  logic [mexm_pkg::SLOT_W-1:0]   scan_cnt_r;
  logic                          err_hit_r;
  logic                          suc_hit_r;
  logic [mexm_pkg::SLOT_W-1:0]   err_slot_r;
  logic [mexm_pkg::SLOT_W-1:0]   suc_slot_r;

  logic                          out_valid_r;
  logic [mexm_pkg::STATUS_W-1:0] out_status_r;
  logic [mexm_pkg::SLOT_W-1:0]   out_slot_r;

  logic                          out_free;
  logic                          in_xfer;

  // Shared compare unit
  logic [mexm_pkg::SHIFT_W-1:0]       cmp_shift;
  logic [mexm_pkg::WIN_W-1:0]         win_aligned;
  logic [mexm_pkg::MAX_PATTERN_LEN-1:0] lane_ok;
  logic                               slot_match;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_matched_slot = out_slot_r;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;

  // Align the last len_rd_r window bytes to lane 0 and compare them
  // lane by lane against the pattern row.
  always_comb begin
    cmp_shift   = mexm_pkg::SHIFT_W'(mexm_pkg::LEN_W'(mexm_pkg::MAX_PATTERN_LEN) - len_rd_r);
    win_aligned = win_r >> {cmp_shift, 3'b000};
    for (int k = 0; k < mexm_pkg::MAX_PATTERN_LEN; k++) begin
      lane_ok[k] = (mexm_pkg::LEN_W'(k) >= len_rd_r) ||
                   (win_aligned[k*mexm_pkg::BYTE_W +: mexm_pkg::BYTE_W] ==
                    pat_rd_r[k*mexm_pkg::BYTE_W +: mexm_pkg::BYTE_W]);
    end
    slot_match = (len_rd_r != '0) && (&lane_ok);
  end

  // Pattern memory: write from the input channel, read one row per fetch
  always_ff @(posedge clk) begin
    if (in_xfer && in_operation == mexm_pkg::OP_WRBYTE) begin
      pat_mem[in_slot][{in_position, 3'b000} +: mexm_pkg::BYTE_W] <= in_data_byte;
    end
    if (state_r == S_FETCH) begin
      pat_rd_r <= pat_mem[scan_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= '0;
      timeout_r   <= mexm_pkg::TIMEOUT_RESET;
      elapsed_r   <= '0;
      waiting_r   <= 1'b0;
      out_valid_r <= 1'b0;
      scan_cnt_r  <= '0;
      err_hit_r   <= 1'b0;
      suc_hit_r   <= 1'b0;
      for (int s = 0; s < mexm_pkg::NUM_PATTERNS; s++) begin
        slot_len_r[s] <= '0;
        slot_err_r[s] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            out_status_r <= mexm_pkg::ST_NONE;
            out_slot_r   <= '0;
            out_valid_r  <= 1'b1;
            case (in_operation)
              mexm_pkg::OP_BYTE: begin
                if (waiting_r) begin
                  // shift in the byte, then scan all slots
                  win_r       <= {in_data_byte, win_r[mexm_pkg::WIN_W-1:mexm_pkg::BYTE_W]};
                  out_valid_r <= 1'b0;
                  scan_cnt_r  <= '0;
                  err_hit_r   <= 1'b0;
                  suc_hit_r   <= 1'b0;
                  state_r     <= S_FETCH;
                end
              end
              mexm_pkg::OP_TICK: begin
                if (waiting_r) begin
                  elapsed_r <= elapsed_inc;
                  if (timeout_r != '0 && elapsed_inc >= timeout_r) begin
                    out_status_r <= mexm_pkg::ST_TIMEOUT;
                    waiting_r    <= 1'b0;
                  end
                end
              end
              mexm_pkg::OP_FAULT: begin
                if (waiting_r) begin
                  out_status_r <= mexm_pkg::ST_FAULT;
                  waiting_r    <= 1'b0;
                end
              end
              mexm_pkg::OP_START: begin
                win_r     <= '0;
                elapsed_r <= '0;
                waiting_r <= 1'b1;
              end
              mexm_pkg::OP_WRHEAD: begin
                slot_len_r[in_slot] <=
                  (in_pattern_length > mexm_pkg::LEN_W'(mexm_pkg::MAX_PATTERN_LEN)) ?
                  mexm_pkg::LEN_W'(mexm_pkg::MAX_PATTERN_LEN) : in_pattern_length;
                slot_err_r[in_slot] <= in_is_error;
              end
              default: begin
                // pattern byte writes go to the memory block; unused codes do nothing
              end
            endcase
          end
        end
        S_FETCH: begin
          len_rd_r <= slot_len_r[scan_cnt_r];
          err_rd_r <= slot_err_r[scan_cnt_r];
          state_r  <= S_CMP;
        end
        S_CMP: begin
          // first hit in each group wins
          if (slot_match && err_rd_r && !err_hit_r) begin
            err_hit_r  <= 1'b1;
            err_slot_r <= scan_cnt_r;
          end
          if (slot_match && !err_rd_r && !suc_hit_r) begin
            suc_hit_r  <= 1'b1;
            suc_slot_r <= scan_cnt_r;
          end
          if (scan_cnt_r == mexm_pkg::SLOT_W'(mexm_pkg::NUM_PATTERNS - 1)) begin
            state_r <= S_DONE;
          end else begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
            state_r    <= S_FETCH;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (err_hit_r) begin
              out_status_r <= mexm_pkg::ST_ERROR;
              out_slot_r   <= err_slot_r;
              waiting_r    <= 1'b0;
            end else if (suc_hit_r) begin
              out_status_r <= mexm_pkg::ST_SUCCESS;
              out_slot_r   <= suc_slot_r;
              waiting_r    <= 1'b0;
            end else begin
              out_status_r <= mexm_pkg::ST_NONE;
              out_slot_r   <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mexm_checker.sv
`default_nettype none
module mexm_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [mexm_pkg::OP_W-1:0]        in_operation,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [mexm_pkg::STATUS_W-1:0]    out_status,
  input wire logic [mexm_pkg::SLOT_W-1:0]      out_matched_slot
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_matched_slot))
    else $error("result changed while stalled");

  // only string matches carry a slot number
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mexm_pkg::ST_SUCCESS && out_status != mexm_pkg::ST_ERROR
    |-> out_matched_slot == '0)
    else $error("slot set without a match");

  // start and pattern writes answer next cycle with no decision
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == mexm_pkg::OP_START ||
    in_operation == mexm_pkg::OP_WRBYTE || in_operation == mexm_pkg::OP_WRHEAD)
    |=> out_valid && out_status == mexm_pkg::ST_NONE)
    else $error("control operation gave a decision");

  // input is never taken while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready with output blocked");

endmodule

bind modem_expect_matcher mexm_checker u_mexm_checker (.*);
`default_nettype wire

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes 6 and 7 have no meaning; the block must answer them with no decision.
  localparam logic [mexm_pkg::OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [mexm_pkg::OP_W-1:0] OP_RSVD_B = 3'd7;

  // Watchdog. The limit sits well above a clean run and above the worst case of
  // ~1300 transfers, each with the longest send gap, a full scan and the longest
  // output stall, plus the single hold-off.
  localparam longint CYCLE_LIMIT = 1_000_000;

  // One transfer on the input channel, one field per port
  typedef struct packed {
    logic [mexm_pkg::OP_W-1:0]   op;
    logic [mexm_pkg::BYTE_W-1:0] data;
    logic [mexm_pkg::SLOT_W-1:0] slot;
    logic [mexm_pkg::POS_W-1:0]  pos;
    logic [mexm_pkg::LEN_W-1:0]  plen;
    logic                        is_err;
  } modem_event_t;

  // One transfer on the result channel
  typedef struct packed {
    mexm_pkg::status_t           status;
    logic [mexm_pkg::SLOT_W-1:0] slot;
  } verdict_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                          in_valid          = 1'b0;
  logic                          in_ready;
  logic [mexm_pkg::OP_W-1:0]     in_operation      = '0;
  logic [mexm_pkg::BYTE_W-1:0]   in_data_byte      = '0;
  logic [mexm_pkg::SLOT_W-1:0]   in_slot           = '0;
  logic [mexm_pkg::POS_W-1:0]    in_position       = '0;
  logic [mexm_pkg::LEN_W-1:0]    in_pattern_length = '0;
  logic                          in_is_error       = 1'b0;
  logic                          out_valid;
  logic                          out_ready         = 1'b0;
  logic [mexm_pkg::STATUS_W-1:0] out_status;
  logic [mexm_pkg::SLOT_W-1:0]   out_matched_slot;
  logic                          cfg_we            = 1'b0;
  logic [mexm_pkg::TICK_W-1:0]   cfg_wdata         = '0;

  modem_expect_matcher u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_data_byte      (in_data_byte),
    .in_slot           (in_slot),
    .in_position       (in_position),
    .in_pattern_length (in_pattern_length),
    .in_is_error       (in_is_error),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_matched_slot  (out_matched_slot),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Matcher state as this bench sees it. It is updated at the moment of each
  // input transfer.
  // ---------------------------------------------------------------------------
  // index MAX_PATTERN_LEN-1 = newest byte
  logic [mexm_pkg::BYTE_W-1:0] window_bytes [mexm_pkg::MAX_PATTERN_LEN];
  logic [mexm_pkg::BYTE_W-1:0] store_bytes  [mexm_pkg::NUM_PATTERNS][mexm_pkg::MAX_PATTERN_LEN];
  logic [mexm_pkg::LEN_W-1:0]  slot_len     [mexm_pkg::NUM_PATTERNS];
  logic                        slot_err     [mexm_pkg::NUM_PATTERNS];
  logic [mexm_pkg::TICK_W-1:0] tick_count;
  logic [mexm_pkg::TICK_W-1:0] timeout_now;
  logic                        armed;             // high while a wait is in progress

  // What the stimulus side has written so far. A slot is enabled only after
  // every byte under its length has been written.
  logic [mexm_pkg::BYTE_W-1:0]          gen_bytes   [mexm_pkg::NUM_PATTERNS]
                                                    [mexm_pkg::MAX_PATTERN_LEN];
  logic [mexm_pkg::MAX_PATTERN_LEN-1:0] gen_written [mexm_pkg::NUM_PATTERNS];
  logic [mexm_pkg::LEN_W-1:0]           gen_len     [mexm_pkg::NUM_PATTERNS];

  modem_event_t line_events_q [$];    // waiting to be offered
  verdict_t     verdicts_q    [$];    // predicted, not yet seen on the output
  modem_event_t offered;
  verdict_t     fresh_verdict;

  int     events_queued, events_sent, verdicts_seen, mismatches, settings_used;
  int     n_success, n_error, n_timeout, n_fault;
  int     gap_left, stall_left, hold_left;
  bit     hold_done;
  bit     calm;                       // stretch with no idling on either side
  longint cycles_run;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Does the window end with the string stored in slot s?
  function automatic bit slot_hit(int s);
    int len;
    len = int'(slot_len[s]);
    if (len == 0) return 1'b0;
    for (int k = 0; k < len; k++)
      if (store_bytes[s][k] !== window_bytes[mexm_pkg::MAX_PATTERN_LEN - len + k])
        return 1'b0;
    return 1'b1;
  endfunction

  // Lowest slot of the given kind that matches; -1 if there is none
  function automatic int first_hit(bit want_err);
    for (int s = 0; s < mexm_pkg::NUM_PATTERNS; s++)
      if (slot_err[s] == want_err && slot_hit(s)) return s;
    return -1;
  endfunction

  // Apply one transfer to the matcher state and return the decision it yields
  function automatic verdict_t judge_event(modem_event_t ev);
    verdict_t v;
    int       hit;
    v.status = mexm_pkg::ST_NONE;
    v.slot   = '0;
    case (ev.op)
      mexm_pkg::OP_BYTE: if (armed) begin
        for (int i = 0; i < mexm_pkg::MAX_PATTERN_LEN - 1; i++)
          window_bytes[i] = window_bytes[i+1];
        window_bytes[mexm_pkg::MAX_PATTERN_LEN-1] = ev.data;
        // error strings take priority over success strings
        hit = first_hit(1'b1);
        if (hit >= 0) begin
          v.status = mexm_pkg::ST_ERROR;
        end else begin
          hit = first_hit(1'b0);
          if (hit >= 0) v.status = mexm_pkg::ST_SUCCESS;
        end
        if (hit >= 0) begin
          v.slot = mexm_pkg::SLOT_W'(hit);
          armed  = 1'b0;
        end
      end
      mexm_pkg::OP_TICK: if (armed) begin
        if (tick_count != '1) tick_count++;    // saturates
        if (timeout_now != '0 && tick_count >= timeout_now) begin
          v.status = mexm_pkg::ST_TIMEOUT;
          armed    = 1'b0;
        end
      end
      mexm_pkg::OP_FAULT: if (armed) begin
        v.status = mexm_pkg::ST_FAULT;
        armed    = 1'b0;
      end
      mexm_pkg::OP_START: begin
        foreach (window_bytes[i]) window_bytes[i] = '0;
        tick_count = '0;
        armed      = 1'b1;
      end
      mexm_pkg::OP_WRBYTE: store_bytes[ev.slot][ev.pos] = ev.data;
      mexm_pkg::OP_WRHEAD: begin
        slot_len[ev.slot] = (ev.plen > mexm_pkg::MAX_PATTERN_LEN) ?
                            mexm_pkg::LEN_W'(mexm_pkg::MAX_PATTERN_LEN) : ev.plen;
        slot_err[ev.slot] = ev.is_err;
      end
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly characters of typical modem responses, with some full-range bytes
  function automatic logic [mexm_pkg::BYTE_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0: return 8'h4F;
      1: return 8'h4B;
      2: return 8'h45;
      3: return 8'h52;
      4: return 8'h0D;
      5: return 8'h0A;
      6: return 8'h00;
      7: return 8'hFF;
      default: return mexm_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // The fields that the operation does not use are random too
  function automatic modem_event_t rand_event(logic [mexm_pkg::OP_W-1:0] op);
    modem_event_t ev;
    ev.op     = op;
    ev.data   = mexm_pkg::BYTE_W'($urandom_range(0, 255));
    ev.slot   = mexm_pkg::SLOT_W'($urandom_range(0, mexm_pkg::NUM_PATTERNS - 1));
    ev.pos    = mexm_pkg::POS_W'($urandom_range(0, mexm_pkg::MAX_PATTERN_LEN - 1));
    ev.plen   = mexm_pkg::LEN_W'($urandom_range(0, 31));
    ev.is_err = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic int pick_stall();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) return 0;
    if (r < 97) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Queue one transfer. Before a header is queued, any byte under the new length
  // that was never written gets written first, so no slot is ever enabled over an
  // unwritten byte.
  task automatic emit(modem_event_t ev);
    modem_event_t fill;
    int           eff;
    if (ev.op == mexm_pkg::OP_WRHEAD) begin
      eff = (ev.plen > mexm_pkg::MAX_PATTERN_LEN) ? mexm_pkg::MAX_PATTERN_LEN : int'(ev.plen);
      for (int p = 0; p < eff; p++) begin
        if (!gen_written[ev.slot][p]) begin
          fill      = rand_event(mexm_pkg::OP_WRBYTE);
          fill.slot = ev.slot;
          fill.pos  = mexm_pkg::POS_W'(p);
          fill.data = pick_char();
          line_events_q.push_back(fill);
          events_queued++;
          gen_written[ev.slot][p] = 1'b1;
          gen_bytes[ev.slot][p]   = fill.data;
        end
      end
      gen_len[ev.slot] = mexm_pkg::LEN_W'(eff);
    end else if (ev.op == mexm_pkg::OP_WRBYTE) begin
      gen_written[ev.slot][ev.pos] = 1'b1;
      gen_bytes[ev.slot][ev.pos]   = ev.data;
    end
    line_events_q.push_back(ev);
    events_queued++;
  endtask

  task automatic put(logic [mexm_pkg::OP_W-1:0] op, logic [mexm_pkg::BYTE_W-1:0] data,
                     int slot = 0, int pos = 0, int plen = 0, bit is_err = 1'b0);
    modem_event_t ev;
    ev.op     = op;
    ev.data   = data;
    ev.slot   = mexm_pkg::SLOT_W'(slot);
    ev.pos    = mexm_pkg::POS_W'(pos);
    ev.plen   = mexm_pkg::LEN_W'(plen);
    ev.is_err = is_err;
    emit(ev);
  endtask

  task automatic send_byte(logic [mexm_pkg::BYTE_W-1:0] b);
    modem_event_t ev;
    ev      = rand_event(mexm_pkg::OP_BYTE);
    ev.data = b;
    emit(ev);
  endtask

  // Load a new response string; mostly short, sometimes long, rarely an
  // over-long length that saturates, or zero to disable the slot.
  task automatic program_slot(int s);
    int len, r;
    r = int'($urandom_range(0, 99));
    if (r < 6)       len = 0;
    else if (r < 70) len = int'($urandom_range(1, 4));
    else if (r < 92) len = int'($urandom_range(5, mexm_pkg::MAX_PATTERN_LEN));
    else             len = int'($urandom_range(mexm_pkg::MAX_PATTERN_LEN + 1, 31));
    for (int k = 0; k < len && k < mexm_pkg::MAX_PATTERN_LEN; k++)
      put(mexm_pkg::OP_WRBYTE, pick_char(), s, k);
    put(mexm_pkg::OP_WRHEAD, mexm_pkg::BYTE_W'($urandom_range(0, 255)), s,
        int'($urandom_range(0, 15)), len, 1'($urandom_range(0, 1)));
  endtask

  // Feed the string of slot s; one time in five a random position, possibly past the end, gets a random character
  task automatic inject(int s);
    int len, broken;
    len    = int'(gen_len[s]);
    broken = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, len)) : -1;
    for (int k = 0; k < len; k++) begin
      if (k == broken) send_byte(pick_char());
      else send_byte(gen_bytes[s][k]);
    end
    if (len == 0) send_byte(pick_char());
  endtask

  // Waits made of a start and then a mix of response text, ticks, faults, restarts,
  // writes during the wait, and reserved operations.
  task automatic random_traffic(int n_items);
    int stop_at, r;
    stop_at = events_queued + n_items;
    while (events_queued < stop_at) begin
      if ($urandom_range(0, 9) < 3)
        program_slot(int'($urandom_range(0, mexm_pkg::NUM_PATTERNS - 1)));
      emit(rand_event(mexm_pkg::OP_START));
      repeat ($urandom_range(2, 24)) begin
        r = int'($urandom_range(0, 99));
        if (r < 35)      send_byte(pick_char());
        else if (r < 60) inject(int'($urandom_range(0, mexm_pkg::NUM_PATTERNS - 1)));
        else if (r < 78) emit(rand_event(mexm_pkg::OP_TICK));
        else if (r < 81) emit(rand_event(mexm_pkg::OP_FAULT));
        else if (r < 84) emit(rand_event(mexm_pkg::OP_START));
        else if (r < 90)
          emit(rand_event($urandom_range(0, 1) ? mexm_pkg::OP_WRBYTE : mexm_pkg::OP_WRHEAD));
        else if (r < 94) emit(rand_event($urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B));
        else             send_byte(mexm_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Nothing left to send and nothing outstanding. Sampled on the falling edge, away
  // from the clocked processes.
  task automatic wait_drained();
    do @(negedge clk);
    while (line_events_q.size() != 0 || in_valid || verdicts_q.size() != 0);
  endtask

  // Config write. The matcher is idle when this runs.
  task automatic set_timeout(logic [mexm_pkg::TICK_W-1:0] ticks);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= ticks;
    timeout_now  = ticks;
    settings_used++;
    @(posedge clk);
    cfg_we      <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    foreach (window_bytes[i]) window_bytes[i] = '0;
    foreach (store_bytes[s, k]) store_bytes[s][k] = '0;
    foreach (slot_len[s]) begin
      slot_len[s]    = '0;
      slot_err[s]    = 1'b0;
      gen_len[s]     = '0;
      gen_written[s] = '0;
    end
    tick_count    = '0;
    timeout_now   = mexm_pkg::TIMEOUT_RESET;
    armed         = 1'b0;
    settings_used = 1;

    // Directed opening, with the reset timeout of 60
    // Idle: received bytes, ticks, faults and reserved codes give no decision
    put(mexm_pkg::OP_BYTE, 8'h41);
    put(mexm_pkg::OP_TICK, 8'h00);
    put(mexm_pkg::OP_FAULT, 8'h00);
    put(OP_RSVD_A, 8'hFF, 7, 15, 31, 1'b1);
    put(OP_RSVD_B, 8'h00);
    // slot 0: success "OK"
    put(mexm_pkg::OP_WRBYTE, 8'h4F, 0, 0);
    put(mexm_pkg::OP_WRBYTE, 8'h4B, 0, 1);
    put(mexm_pkg::OP_WRHEAD, 8'h00, 0, 0, 2, 1'b0);
    // slot 7: error on a single 0xFF; top position written, left outside the length
    put(mexm_pkg::OP_WRBYTE, 8'hFF, 7, 0);
    put(mexm_pkg::OP_WRBYTE, 8'h5A, 7, 15);
    put(mexm_pkg::OP_WRHEAD, 8'h00, 7, 0, 1, 1'b1);
    // slot 3: error on 00 FF. It matches against the zeros left in the window by start.
    put(mexm_pkg::OP_WRBYTE, 8'h00, 3, 0);
    put(mexm_pkg::OP_WRBYTE, 8'hFF, 3, 1);
    put(mexm_pkg::OP_WRHEAD, 8'h00, 3, 0, 2, 1'b1);
    // slots 3 and 7 both match; the lower slot wins
    put(mexm_pkg::OP_START, 8'h00);
    put(mexm_pkg::OP_BYTE, 8'hFF);
    // success after two bytes
    put(mexm_pkg::OP_START, 8'h00);
    put(mexm_pkg::OP_BYTE, 8'h4F);
    put(mexm_pkg::OP_BYTE, 8'h4B);
    // line fault ends a wait; after that the block is idle again
    put(mexm_pkg::OP_START, 8'h00);
    put(mexm_pkg::OP_BYTE, 8'h4F);
    put(mexm_pkg::OP_FAULT, 8'h00);
    put(mexm_pkg::OP_BYTE, 8'h4B);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    random_traffic(220);

    // timeout after one tick
    wait_drained();
    set_timeout(16'd1);
    put(mexm_pkg::OP_START, 8'h00);
    put(mexm_pkg::OP_TICK, 8'h00);
    put(mexm_pkg::OP_TICK, 8'h00);
    random_traffic(220);

    // Timeout off
    wait_drained();
    set_timeout(16'd0);
    random_traffic(220);

    // Highest limit
    wait_drained();
    set_timeout(16'hFFFF);
    random_traffic(220);

    wait_drained();
    set_timeout(16'd3);
    random_traffic(220);

    // Drain, then give any extra result time to show up
    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d input transfers, %0d results, %0d timeout settings",
             events_sent, verdicts_seen, settings_used);
    $display("decisions: %0d success, %0d error, %0d timeout, %0d line fault",
             n_success, n_error, n_timeout, n_fault);
    if (mismatches == 0) begin
      $display("PASS modem_expect_matcher");
    end else begin
      $display("FAIL modem_expect_matcher");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued events and predicts each one on its transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left  = 0;
    end else begin
      if (in_valid && in_ready) begin
        fresh_verdict = judge_event(offered);
        verdicts_q.push_back(fresh_verdict);
        events_sent++;
        case (fresh_verdict.status)
          mexm_pkg::ST_SUCCESS: n_success++;
          mexm_pkg::ST_ERROR:   n_error++;
          mexm_pkg::ST_TIMEOUT: n_timeout++;
          mexm_pkg::ST_FAULT:   n_fault++;
          default: ;
        endcase
        // switch now and then between idling and back-to-back traffic
        if ($urandom_range(0, 149) == 0) calm = !calm;
      end
      // Valid holds with the same payload until its transfer
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_events_q.size() != 0) begin
          offered = line_events_q.pop_front();
          in_operation      <= offered.op;
          in_data_byte      <= offered.data;
          in_slot           <= offered.slot;
          in_position       <= offered.pos;
          in_pattern_length <= offered.plen;
          in_is_error       <= offered.is_err;
          in_valid          <= 1'b1;
          gap_left = calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results in order and applies output backpressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdicts_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 20)
            $display("%0t: unexpected result, status %0d slot %0d", $time, out_status,
                     out_matched_slot);
        end else begin
          fresh_verdict = verdicts_q.pop_front();
          if (out_status !== fresh_verdict.status) begin
            mismatches++;
            if (mismatches <= 20)
              $display("%0t: status expected %0d, got %0d", $time, fresh_verdict.status,
                       out_status);
          end
          if (out_matched_slot !== fresh_verdict.slot) begin
            mismatches++;
            if (mismatches <= 20)
              $display("%0t: matched_slot expected %0d, got %0d", $time, fresh_verdict.slot,
                       out_matched_slot);
          end
        end
      end
      // A single long hold-off while the sender keeps offering, so the block
      // backs up and drops in_ready
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && verdicts_seen >= 400) begin
        hold_done  = 1'b1;
        hold_left  = 300;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = calm ? 0 : pick_stall();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles_run,
               verdicts_q.size());
      $display("FAIL modem_expect_matcher");
      $finish;
    end
  end

endmodule
